// ----- src/llss_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths and constants of the logistic loss / sigmoid stream core.
// No dependencies.
package llss_pkg;

   localparam int MARGIN_W      = 24;
   localparam int LOSS_W        = 24;
   localparam int COUNT_W       = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam int SUM_BITS_DEF  = 48;
   localparam int QUEUE_DEPTH   = 2;
   localparam int EXP_TERMS     = 20;
   localparam int LOG_TERMS     = 16;
   localparam int WHOLE_LIMIT   = 32;

   // Classified sample as it travels from the front end to the evaluator.
   typedef struct packed {
      logic signed [MARGIN_W-1:0] margin;
      logic [MARGIN_W-1:0]        mag;
      logic                       label;
      logic                       last_sample;
      logic                       exp_zero;
   } llss_item_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } llss_q_status_type;

   // exp(-f) in Q32, truncated Taylor series; elaboration time only.
   function automatic logic [63:0] exp_neg_frac_q32(input logic [63:0] f);
      logic [63:0] v;
      logic [63:0] term;
      v    = 64'd1 << 32;
      term = 64'd1 << 32;
      for (int k = 1; k <= EXP_TERMS; k++) begin
         term = ((term * f) >> 32) / 64'(k);
         if (k % 2 == 1) v = v - term;
         else            v = v + term;
      end
      return v;
   endfunction

   // exp(-1) in Q32 as the rounded square of exp(-1/2).
   function automatic logic [31:0] exp_neg_one_q32();
      logic [63:0] h;
      logic [63:0] p;
      h = exp_neg_frac_q32(64'h8000_0000);
      p = h * h + (64'd1 << 31);
      return p[63:32];
   endfunction

   localparam logic [31:0] EXP_NEG_ONE = exp_neg_one_q32();

endpackage

// ----- src/llss_if.sv -----
`timescale 1ns / 1ps
// Sample and result channels of the logistic loss core (valid/ready).
// Depends on llss_pkg.
interface llss_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [llss_pkg::MARGIN_W-1:0] margin;
   logic                                 label;
   logic                                 last_sample;

   modport source(output valid, margin, label, last_sample, input ready);
   modport sink(input valid, margin, label, last_sample, output ready);
endinterface

interface llss_rsp_if #(
   parameter int FRAC_BITS = llss_pkg::FRAC_BITS_DEF,
   parameter int SUM_BITS  = llss_pkg::SUM_BITS_DEF
);
   logic                           valid;
   logic                           ready;
   logic [FRAC_BITS:0]             probability;
   logic [llss_pkg::LOSS_W-1:0]    sample_loss;
   logic [SUM_BITS-1:0]            total_loss;
   logic [llss_pkg::COUNT_W-1:0]   sample_count;
   logic                           is_last;

   modport source(output valid, probability, sample_loss, total_loss, sample_count,
                  is_last, input ready);
   modport sink(input valid, probability, sample_loss, total_loss, sample_count,
                is_last, output ready);
endinterface

// ----- src/logistic_loss_sigmoid_stream_core.sv -----
`timescale 1ns / 1ps
// Logistic loss and sigmoid stream core: top level. Depends on llss_pkg, llss_if,
// llss_front, llss_fifo and llss_back.
// Sequence: one sample takes 38 divider passes, plus one exp(-1) step per whole unit
//   of |margin|, or 18 passes when |margin| >= 32; all passes go through the shared
//   divider. The evaluator takes a new sample only once it is done with the last;
//   the queue takes two more samples meanwhile.
// Reset (synchronous, active high): queue emptied, loss sum and count cleared.
module logistic_loss_sigmoid_stream_core #(
   parameter int FRAC_BITS = llss_pkg::FRAC_BITS_DEF,
   parameter int SUM_BITS  = llss_pkg::SUM_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   llss_req_if.sink    req_chan,
   llss_rsp_if.source  rsp_chan
);
   // Front/back split: the front end classifies each beat (|t|, zero-exp flag)
   // and drops it into a two-entry queue; the evaluator drains the queue one
   // sample at a time and holds its result in an output register, so a stalled
   // result side does not block the sample side until the queue fills.
   logic                        q_push;
   logic                        q_pop;
   llss_pkg::llss_item_type     push_item;
   llss_pkg::llss_item_type     pop_item;
   llss_pkg::llss_q_status_type q_status;

   llss_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .req       (req_chan),
      .q_status  (q_status),
      .push      (q_push),
      .push_item (push_item)
   );

   // Hold up to two classified samples between the two halves.
   llss_fifo #(.DEPTH(llss_pkg::QUEUE_DEPTH)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .status    (q_status)
   );

   // Evaluate exp, reciprocal and log series; accumulate loss; advance the
   // running sum and count, clearing both after a beat marked last.
   llss_back #(.FRAC_BITS(FRAC_BITS), .SUM_BITS(SUM_BITS)) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_status.not_empty),
      .q_item  (pop_item),
      .q_pop   (q_pop),
      .rsp     (rsp_chan)
   );

   // The front end must never push into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_status.full))
      else $error("sample pushed into full queue");

   // The evaluator only drains a queue that holds a sample.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_status.not_empty)
      else $error("sample popped from empty queue");

   // No result is presented right after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result valid after reset");
endmodule

// ----- src/llss_front.sv -----
`timescale 1ns / 1ps
// Front end: take samples, form |margin| and flag margins whose exp term is zero.
// Depends on llss_pkg and llss_if.
module llss_front #(
   parameter int FRAC_BITS = llss_pkg::FRAC_BITS_DEF
) (
   llss_req_if.sink                     req,
   input  llss_pkg::llss_q_status_type  q_status,
   output logic                         push,
   output llss_pkg::llss_item_type      push_item
);
   logic [llss_pkg::MARGIN_W-1:0] mag;

   assign req.ready = !q_status.full;
   assign push      = req.valid && req.ready;

   always_comb begin
      if (req.margin[llss_pkg::MARGIN_W-1]) begin
         mag = llss_pkg::MARGIN_W'(-req.margin);
      end else begin
         mag = llss_pkg::MARGIN_W'(req.margin);
      end
      push_item.margin      = req.margin;
      push_item.mag         = mag;
      push_item.label       = req.label;
      push_item.last_sample = req.last_sample;
      push_item.exp_zero    = (mag >> FRAC_BITS) >=
                              llss_pkg::MARGIN_W'(llss_pkg::WHOLE_LIMIT);
   end
endmodule

// ----- src/llss_fifo.sv -----
`timescale 1ns / 1ps
// Short sample queue between front end and evaluator.
// Depends on llss_pkg.
module llss_fifo #(
   parameter int DEPTH = llss_pkg::QUEUE_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  llss_pkg::llss_item_type      push_item,
   input  logic                         pop,
   output llss_pkg::llss_item_type      pop_item,
   output llss_pkg::llss_q_status_type  status
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW = $clog2(DEPTH + 1);

   llss_pkg::llss_item_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff, wr_ptr_in, rd_ptr_in;
   logic [LW-1:0] level_ff, level_in;

   assign status.full      = level_ff == LW'(DEPTH);
   assign status.not_empty = level_ff != '0;
   assign pop_item         = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) level_in = level_ff + 1'b1;
      else if (pop && !push) level_in = level_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_item;
   end
endmodule

// ----- src/llss_div.sv -----
`timescale 1ns / 1ps
// Radix-2 restoring divider, one quotient bit per cycle; done pulses with the result.
// No dependencies.
module llss_div #(
   parameter int DVW = 49,
   parameter int DSW = 18
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [DVW-1:0] dividend,
   input  logic [DSW-1:0] divisor,
   output logic           done,
   output logic [DVW-1:0] quotient
);
   localparam int CW = $clog2(DVW + 1);

   logic           busy_ff, done_ff;
   logic [CW-1:0]  cnt_ff;
   logic [DVW-1:0] quo_ff, quo_in;
   logic [DSW-1:0] rem_ff, rem_in, dsr_ff;
   logic [DSW:0]   trial, diff;

   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      trial = {rem_ff, quo_ff[DVW-1]};
      diff  = trial - {1'b0, dsr_ff};
      if (trial >= {1'b0, dsr_ff}) begin
         rem_in = diff[DSW-1:0];
         quo_in = {quo_ff[DVW-2:0], 1'b1};
      end else begin
         rem_in = trial[DSW-1:0];
         quo_in = {quo_ff[DVW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(DVW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end
endmodule

// ----- src/llss_back.sv -----
`timescale 1ns / 1ps
// Evaluator: sequencer over one multiplier and the divider, loss sum, result register.
// Depends on llss_pkg, llss_if and llss_div.
module llss_back #(
   parameter int FRAC_BITS = llss_pkg::FRAC_BITS_DEF,
   parameter int SUM_BITS  = llss_pkg::SUM_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  llss_pkg::llss_item_type  q_item,
   output logic                     q_pop,
   llss_rsp_if.source               rsp
);
   localparam int F     = FRAC_BITS;
   localparam int DVW   = F + 33;
   localparam int DSW   = F + 2;
   localparam int SUMW1 = SUM_BITS + 1;
   localparam int LW    = llss_pkg::LOSS_W;
   localparam int CNTW  = llss_pkg::COUNT_W;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_EMUL  = 4'd1;
   localparam logic [3:0] S_EDIV  = 4'd2;
   localparam logic [3:0] S_EWAIT = 4'd3;
   localparam logic [3:0] S_WCHK  = 4'd4;
   localparam logic [3:0] S_WACC  = 4'd5;
   localparam logic [3:0] S_ZDIV  = 4'd6;
   localparam logic [3:0] S_ZWAIT = 4'd7;
   localparam logic [3:0] S_ZSQ   = 4'd8;
   localparam logic [3:0] S_ZSQW  = 4'd9;
   localparam logic [3:0] S_LDIV  = 4'd10;
   localparam logic [3:0] S_LWAIT = 4'd11;
   localparam logic [3:0] S_LSTEP = 4'd12;
   localparam logic [3:0] S_QDIV  = 4'd13;
   localparam logic [3:0] S_QWAIT = 4'd14;
   localparam logic [3:0] S_FIN   = 4'd15;

   logic [3:0]              state_ff, state_in;
   llss_pkg::llss_item_type item_ff, item_in;
   logic [31:0]             frac_ff, frac_in;
   logic [4:0]              whole_ff, whole_in;
   logic [4:0]              k_ff, k_in;
   logic [32:0]             v_ff, v_in, term_ff, term_in;
   logic [F:0]              e_ff, e_in, q_ff, q_in;
   logic [31:0]             z_ff, z_in, zsq_ff, zsq_in, p_ff, p_in;
   logic [33:0]             s_ff, s_in;
   logic [65:0]             prod_ff, prod_r;
   logic [32:0]             mul_a, mul_b, rnd33;

   logic                    div_start, div_done;
   logic [DVW-1:0]          div_dividend, div_quot;
   logic [DSW-1:0]          div_divisor, d_w;

   logic [SUM_BITS-1:0]     acc_ff, acc_in;
   logic [CNTW-1:0]         seen_ff, seen_in;
   logic                    out_valid_ff, out_valid_in;
   logic [F:0]              prob_ff, prob_in;
   logic [LW-1:0]           loss_ff, loss_in;
   logic [SUM_BITS-1:0]     total_ff, total_in;
   logic [CNTW-1:0]         count_ff, count_in;
   logic                    last_ff, last_in;

   logic [33:0]             v_r;
   logic [34:0]             l_r;
   logic [F:0]              ln_term, one_w;
   logic signed [26:0]      t_x, l_x, pos_x, yt_x, loss_x;
   logic [LW-1:0]           lu;
   logic [SUM_BITS:0]       sum_w;
   logic [SUM_BITS-1:0]     sum_sat;
   logic [CNTW-1:0]         seen_inc;
   logic                    fire;

   llss_div #(.DVW(DVW), .DSW(DSW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign q_pop             = (state_ff == S_IDLE) && q_valid;
   assign rsp.valid         = out_valid_ff;
   assign rsp.probability   = prob_ff;
   assign rsp.sample_loss   = loss_ff;
   assign rsp.total_loss    = total_ff;
   assign rsp.sample_count  = count_ff;
   assign rsp.is_last       = last_ff;

   // shared multiplier operands
   always_comb begin
      unique case (state_ff)
         S_EMUL:  begin mul_a = term_ff;         mul_b = {1'b0, frac_ff}; end
         S_WCHK:  begin mul_a = v_ff;            mul_b = {1'b0, llss_pkg::EXP_NEG_ONE}; end
         S_ZSQ:   begin mul_a = {1'b0, z_ff};    mul_b = {1'b0, z_ff}; end
         S_LWAIT: begin mul_a = {1'b0, p_ff};    mul_b = {1'b0, zsq_ff}; end
         default: begin mul_a = '0;              mul_b = '0; end
      endcase
   end

   assign prod_r = prod_ff + (66'd1 << 31);
   assign rnd33  = prod_r[64:32];
   assign d_w    = DSW'(e_ff) + (DSW'(1) << F);

   // divider commands
   always_comb begin
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      unique case (state_ff)
         S_EDIV: begin
            div_start    = 1'b1;
            div_dividend = DVW'(prod_ff[63:32]);
            div_divisor  = DSW'(k_ff);
         end
         S_ZDIV: begin
            div_start    = 1'b1;
            div_dividend = {e_ff, 32'd0};
            div_divisor  = DSW'(e_ff) + (DSW'(1) << (F + 1));
         end
         S_LDIV: begin
            div_start    = 1'b1;
            div_dividend = DVW'(p_ff);
            div_divisor  = DSW'({k_ff, 1'b1});
         end
         S_QDIV: begin
            div_start    = 1'b1;
            div_dividend = (DVW'(1) << (2 * F)) + DVW'(d_w >> 1);
            div_divisor  = d_w;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   // final arithmetic: log term, loss clamp, saturating sum and count
   always_comb begin
      v_r     = {1'b0, v_ff} + (34'd1 << (31 - F));
      l_r     = {s_ff, 1'b0} + (35'd1 << (31 - F));
      ln_term = l_r[32-F +: F+1];
      one_w   = (F+1)'(1) << F;
      t_x     = 27'(item_ff.margin);
      l_x     = 27'(signed'({1'b0, ln_term}));
      pos_x   = (t_x > 27'sd0) ? t_x : 27'sd0;
      yt_x    = item_ff.label ? t_x : 27'sd0;
      loss_x  = pos_x + l_x - yt_x;
      if (loss_x < 27'sd0) begin
         lu = '0;
      end else if (loss_x > 27'sd16777215) begin
         lu = '1;
      end else begin
         lu = loss_x[LW-1:0];
      end
      sum_w    = {1'b0, acc_ff} + SUMW1'(lu);
      sum_sat  = sum_w[SUM_BITS] ? '1 : sum_w[SUM_BITS-1:0];
      seen_inc = (seen_ff == '1) ? seen_ff : seen_ff + 1'b1;
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      frac_in      = frac_ff;
      whole_in     = whole_ff;
      k_in         = k_ff;
      v_in         = v_ff;
      term_in      = term_ff;
      e_in         = e_ff;
      q_in         = q_ff;
      z_in         = z_ff;
      zsq_in       = zsq_ff;
      p_in         = p_ff;
      s_in         = s_ff;
      acc_in       = acc_ff;
      seen_in      = seen_ff;
      prob_in      = prob_ff;
      loss_in      = loss_ff;
      total_in     = total_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      fire         = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               item_in  = q_item;
               frac_in  = 32'(q_item.mag[F-1:0]) << (32 - F);
               whole_in = 5'(q_item.mag >> F);
               v_in     = 33'd1 << 32;
               term_in  = 33'd1 << 32;
               k_in     = 5'd1;
               e_in     = '0;
               state_in = q_item.exp_zero ? S_ZDIV : S_EMUL;
            end
         end
         S_EMUL:  state_in = S_EDIV;
         S_EDIV:  state_in = S_EWAIT;
         S_EWAIT: begin
            if (div_done) begin
               term_in = {1'b0, div_quot[31:0]};
               v_in    = k_ff[0] ? v_ff - {1'b0, div_quot[31:0]}
                                 : v_ff + {1'b0, div_quot[31:0]};
               if (k_ff == 5'(llss_pkg::EXP_TERMS)) begin
                  state_in = S_WCHK;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = S_EMUL;
               end
            end
         end
         S_WCHK: begin
            if (whole_ff == '0) begin
               e_in     = v_r[32-F +: F+1];
               state_in = S_ZDIV;
            end else begin
               state_in = S_WACC;
            end
         end
         S_WACC: begin
            v_in     = rnd33;
            whole_in = whole_ff - 1'b1;
            state_in = S_WCHK;
         end
         S_ZDIV:  state_in = S_ZWAIT;
         S_ZWAIT: begin
            if (div_done) begin
               z_in     = div_quot[31:0];
               state_in = S_ZSQ;
            end
         end
         S_ZSQ:   state_in = S_ZSQW;
         S_ZSQW: begin
            zsq_in   = rnd33[31:0];
            p_in     = z_ff;
            s_in     = '0;
            k_in     = '0;
            state_in = S_LDIV;
         end
         S_LDIV:  state_in = S_LWAIT;
         S_LWAIT: begin
            if (div_done) begin
               s_in     = s_ff + 34'(div_quot[31:0]);
               state_in = S_LSTEP;
            end
         end
         S_LSTEP: begin
            p_in = rnd33[31:0];
            if (k_ff == 5'(llss_pkg::LOG_TERMS - 1)) begin
               state_in = S_QDIV;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = S_LDIV;
            end
         end
         S_QDIV:  state_in = S_QWAIT;
         S_QWAIT: begin
            if (div_done) begin
               q_in     = div_quot[F:0];
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!out_valid_ff || rsp.ready) begin
               fire     = 1'b1;
               prob_in  = item_ff.margin[llss_pkg::MARGIN_W-1] ? one_w - q_ff : q_ff;
               loss_in  = lu;
               total_in = sum_sat;
               count_in = seen_inc;
               last_in  = item_ff.last_sample;
               acc_in   = item_ff.last_sample ? '0 : sum_sat;
               seen_in  = item_ff.last_sample ? '0 : seen_inc;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      out_valid_in = fire || (out_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         acc_ff       <= '0;
         seen_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         seen_ff      <= seen_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      frac_ff  <= frac_in;
      whole_ff <= whole_in;
      k_ff     <= k_in;
      v_ff     <= v_in;
      term_ff  <= term_in;
      e_ff     <= e_in;
      q_ff     <= q_in;
      z_ff     <= z_in;
      zsq_ff   <= zsq_in;
      p_ff     <= p_in;
      s_ff     <= s_in;
      prod_ff  <= mul_a * mul_b;
      prob_ff  <= prob_in;
      loss_ff  <= loss_in;
      total_ff <= total_in;
      count_ff <= count_in;
      last_ff  <= last_in;
   end
endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench of logistic_loss_sigmoid_stream_core: streams margins through the
// core and checks every response against an in-bench fixed-point model.
// Depends on llss_pkg, llss_if and the core RTL.
module tb_top;

   localparam int  FB        = llss_pkg::FRAC_BITS_DEF;
   localparam int  SB        = llss_pkg::SUM_BITS_DEF;
   localparam int  MW        = llss_pkg::MARGIN_W;
   localparam int  LSW       = llss_pkg::LOSS_W;
   localparam int  CW        = llss_pkg::COUNT_W;
   localparam int  N_RANDOM  = 750;
   localparam longint CYCLE_LIMIT = 12_000_000;
   localparam int  LONG_HOLD = 10_000;

   typedef struct {
      logic signed [MW-1:0] margin;
      logic                 label;
      logic                 last_sample;
      bit                   drain;   // pause marker: wait for all responses
   } sample_type;

   typedef struct {
      logic [FB:0]     probability;
      logic [LSW-1:0]  sample_loss;
      logic [SB-1:0]   total_loss;
      logic [CW-1:0]   sample_count;
      logic            is_last;
   } loss_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   llss_req_if req_chan ();
   llss_rsp_if #(.FRAC_BITS(FB), .SUM_BITS(SB)) rsp_chan ();

   logistic_loss_sigmoid_stream_core #(.FRAC_BITS(FB), .SUM_BITS(SB)) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   sample_type   pending_samples[$];
   loss_rsp_type expected_rsps[$];
   logic [SB-1:0]  model_sum   = '0;
   logic [CW-1:0]  model_count = '0;
   int     errors = 0;
   int     rsp_seen = 0;
   longint cycles = 0;
   bit     req_fire = 1'b0;
   bit     stim_done = 1'b0;

   // ---------------------------------------------------------------- model
   function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
      return (a * b + (64'd1 << 31)) >> 32;
   endfunction

   // Taylor series of exp(-f), f in Q32 below one.
   function automatic logic [63:0] exp_frac_q32(input logic [63:0] f);
      logic [63:0] v, term;
      v    = 64'd1 << 32;
      term = 64'd1 << 32;
      for (int k = 1; k <= 20; k++) begin
         term = ((term * f) >> 32) / 64'(k);
         if (k % 2 == 1) v = v - term;
         else            v = v + term;
      end
      return v;
   endfunction

   function automatic logic [63:0] to_frac(input logic [63:0] v);
      return (v + (64'd1 << (31 - FB))) >> (32 - FB);
   endfunction

   // round(2^F * exp(-mag/2^F)), zero once the whole part reaches 32.
   function automatic logic [63:0] exp_of_mag(input logic [63:0] mag);
      logic [63:0] whole, v, c1, h;
      whole = mag >> FB;
      if (whole >= 32) return 64'd0;
      v  = exp_frac_q32((mag & ((64'd1 << FB) - 1)) << (32 - FB));
      h  = exp_frac_q32(64'd1 << 31);
      c1 = qmul(h, h);
      for (longint i = 0; i < whole; i++) v = qmul(v, c1);
      return to_frac(v);
   endfunction

   // round(2^F * ln(1 + e/2^F)) through 2*atanh(e / (2*2^F + e)).
   function automatic logic [63:0] log1p_of_exp(input logic [63:0] e);
      logic [63:0] z, zsq, p, s;
      z   = (e << 32) / ((64'd1 << (FB + 1)) + e);
      zsq = qmul(z, z);
      p   = z;
      s   = 64'd0;
      for (int k = 0; k < 16; k++) begin
         s = s + p / 64'(2 * k + 1);
         p = qmul(p, zsq);
      end
      return to_frac(2 * s);
   endfunction

   // Work out the response of one accepted sample and advance the running sums.
   function automatic loss_rsp_type predict_loss(input sample_type s);
      loss_rsp_type r;
      longint       t, loss;
      logic [63:0]  mag, e, d, q, one, lu, sum_max;
      t   = longint'(s.margin);
      mag = (t < 0) ? 64'(-t) : 64'(t);
      one = 64'd1 << FB;
      e   = exp_of_mag(mag);
      d   = one + e;
      q   = ((64'd1 << (2 * FB)) + (d >> 1)) / d;
      loss = ((t > 0) ? t : 0) + longint'(log1p_of_exp(e)) - (s.label ? t : 0);
      if (loss < 0) loss = 0;
      if (loss > 16777215) loss = 16777215;
      lu = 64'(loss);
      sum_max = {SB{1'b1}};
      // saturate the sum and the count instead of wrapping
      if (64'(model_sum) > sum_max - lu) model_sum = '1;
      else model_sum = model_sum + SB'(lu);
      if (model_count != '1) model_count = model_count + 1'b1;
      r.probability  = (t >= 0) ? q[FB:0] : (FB+1)'(one - q);
      r.sample_loss  = lu[LSW-1:0];
      r.total_loss   = model_sum;
      r.sample_count = model_count;
      r.is_last      = s.last_sample;
      if (s.last_sample) begin
         model_sum   = '0;
         model_count = '0;
      end
      return r;
   endfunction

   // ------------------------------------------------------------- stimulus
   function automatic sample_type mk(input int m, input bit y, input bit l);
      sample_type s;
      s.margin      = MW'(m);
      s.label       = y;
      s.last_sample = l;
      s.drain       = 1'b0;
      return s;
   endfunction

   initial begin
      sample_type s;
      int         m;
      // extremes, sign boundaries, the zero-exp threshold, both labels
      pending_samples.push_back(mk(0, 0, 0));
      pending_samples.push_back(mk(0, 1, 0));
      pending_samples.push_back(mk(1, 1, 0));
      pending_samples.push_back(mk(-1, 0, 0));
      pending_samples.push_back(mk(8388607, 0, 0));
      pending_samples.push_back(mk(8388607, 1, 0));
      pending_samples.push_back(mk(-8388608, 1, 0));
      pending_samples.push_back(mk(-8388608, 0, 1));
      pending_samples.push_back(mk(32 << 16, 0, 0));
      pending_samples.push_back(mk((32 << 16) - 1, 1, 0));
      pending_samples.push_back(mk(-(32 << 16), 1, 0));
      pending_samples.push_back(mk(-(32 << 16) + 1, 0, 0));
      pending_samples.push_back(mk(65536, 0, 0));
      pending_samples.push_back(mk(-65536, 1, 0));
      pending_samples.push_back(mk(32768, 1, 0));
      pending_samples.push_back(mk(-98304, 0, 1));
      pending_samples.push_back(mk(-5 << 16, 1, 1));   // one-sample data set
      s = mk(0, 0, 0);
      s.drain = 1'b1;
      pending_samples.push_back(s);
      for (int i = 0; i < N_RANDOM; i++) begin
         case ($urandom_range(0, 9))
            0, 1, 2: m = int'($urandom_range(0, 32'hFF_FFFF)) - (1 << 23) * 0;
            default: m = int'($urandom_range(0, 16 << 16)) - (8 << 16);
         endcase
         pending_samples.push_back(mk(m, 1'($urandom_range(0, 1)),
                                      $urandom_range(0, 15) == 0));
         if (i == 400) begin
            s = mk(0, 0, 0);
            s.drain = 1'b1;
            pending_samples.push_back(s);
         end
      end
   end

   // ------------------------------------------------------------ driver
   int  burst_left = 0;
   int  gap_left   = 0;
   bit  draining   = 1'b0;

   initial begin
      req_chan.valid       = 1'b0;
      req_chan.margin      = '0;
      req_chan.label       = 1'b0;
      req_chan.last_sample = 1'b0;
      rsp_chan.ready       = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) req_fire <= req_chan.valid && req_chan.ready && !reset;

   // Change inputs on the falling edge; hold a beat until it was taken.
   always @(negedge clock) begin
      if (!reset && !(req_chan.valid && !req_fire)) begin
         if (draining) begin
            if (expected_rsps.size() == 0) draining = 1'b0;
            req_chan.valid <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            req_chan.valid <= 1'b0;
         end else if (pending_samples.size() == 0) begin
            req_chan.valid <= 1'b0;
            stim_done = 1'b1;
         end else if (pending_samples[0].drain) begin
            void'(pending_samples.pop_front());
            draining = 1'b1;
            req_chan.valid <= 1'b0;
         end else begin
            sample_type s;
            s = pending_samples.pop_front();
            req_chan.valid       <= 1'b1;
            req_chan.margin      <= s.margin;
            req_chan.label       <= s.label;
            req_chan.last_sample <= s.last_sample;
            if (burst_left > 0) burst_left--;
            else begin
               burst_left = $urandom_range(1, 6);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 3000);
            end
         end
      end
   end

   // Predict on every accepted sample beat.
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) begin
         sample_type s;
         s.margin      = req_chan.margin;
         s.label       = req_chan.label;
         s.last_sample = req_chan.last_sample;
         s.drain       = 1'b0;
         expected_rsps.push_back(predict_loss(s));
      end
   end

   // ------------------------------------------------------------ receiver
   int  hold_left = 0;
   bit  held_once = 1'b0;
   int  stall_phase = 0;

   // Stall on a rotating pattern; once, hold off long enough to back up the core.
   always @(negedge clock) begin
      if (reset) rsp_chan.ready <= 1'b0;
      else if (!held_once && rsp_seen == 30) begin
         held_once = 1'b1;
         hold_left = LONG_HOLD;
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         stall_phase = (stall_phase + 1) % 5000;
         if (stall_phase < 2500) rsp_chan.ready <= 1'b1;
         else rsp_chan.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // ------------------------------------------------------------ monitor
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         loss_rsp_type x;
         rsp_seen++;
         if (expected_rsps.size() == 0) begin
            $error("response beat with nothing expected");
            errors++;
         end else begin
            x = expected_rsps.pop_front();
            if (rsp_chan.probability !== x.probability) begin
               $error("probability expected %0d actual %0d", x.probability,
                      rsp_chan.probability);
               errors++;
            end
            if (rsp_chan.sample_loss !== x.sample_loss) begin
               $error("sample_loss expected %0d actual %0d", x.sample_loss,
                      rsp_chan.sample_loss);
               errors++;
            end
            if (rsp_chan.total_loss !== x.total_loss) begin
               $error("total_loss expected %0d actual %0d", x.total_loss,
                      rsp_chan.total_loss);
               errors++;
            end
            if (rsp_chan.sample_count !== x.sample_count) begin
               $error("sample_count expected %0d actual %0d", x.sample_count,
                      rsp_chan.sample_count);
               errors++;
            end
            if (rsp_chan.is_last !== x.is_last) begin
               $error("is_last expected %0d actual %0d", x.is_last, rsp_chan.is_last);
               errors++;
            end
         end
      end
   end

   // ------------------------------------------------------------ end of run
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("logistic_loss_sigmoid_stream_core verification failed");
         $finish;
      end
   end

   initial begin
      wait (stim_done && !req_chan.valid);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (2500) @(posedge clock);
      if (errors == 0 && expected_rsps.size() == 0)
         $display("logistic_loss_sigmoid_stream_core verification clean");
      else
         $display("logistic_loss_sigmoid_stream_core verification failed");
      $finish;
   end

endmodule
